[rtl/whrs_pkg.sv]
// ----------------------------------------------------------------------------
// whrs_pkg: shared types and helpers for the weighted histogram
// Holds the command codes, the sequencer states and the saturating add.
// ----------------------------------------------------------------------------
package whrs_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned WEIGHT_W = 16;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned RANGE_W = 11;
  localparam logic [DATA_W-1:0] SAT_MAX = '1;

  typedef enum logic [1:0] {
    CMD_CLEAR_ALL = 2'd0,
    CMD_ADD       = 2'd1,
    CMD_RANGE     = 2'd2,
    CMD_CLEAR_MAX = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD,
    ST_RANGE,
    ST_DONE
  } state_t;

  // Add two 32-bit values, stick at all ones on overflow.
  function automatic logic [DATA_W-1:0] sat_add32(input logic [DATA_W-1:0] a,
                                                 input logic [DATA_W-1:0] b);
    logic [DATA_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DATA_W] ? SAT_MAX : s[DATA_W-1:0];
  endfunction

endpackage

[rtl/whrs_ram.sv]
// ----------------------------------------------------------------------------
// whrs_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module whrs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/weighted_histogram_range_sum.sv]
// ----------------------------------------------------------------------------
// weighted_histogram_range_sum: weighted histogram with range sums
// Bin store in RAM, updated by read-modify-write and summed by a bin walk.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_ stream; s_tuser carries the command (clear all,
//   add sample, range sum, clear maximum), s_tdata the sample and range bounds.
//   Results leave on the m_ stream: m_tuser[0] is the status (1 = sample out
//   of range), m_tdata holds the range total and the floored running maximum.
//   The cfg_wr_en / cfg_wr_data port sets the per-sample weight (reset 1).
//   Structure: one shared RAM read port and one saturating adder do all the work.
//   An add request reads the bin, then writes the bin. A range sum accepts the
//   request, issues one read per bin, folds the last read and closes the walk,
//   then loads the output register; an empty range skips the reads. Clear-maximum
//   and zero-sample requests finish in the idle state; a rejected sample goes
//   straight to the done state. A clear-all request, and reset, run a clearing
//   pass over all NUM_BINS bins of the store, with s_tready held low.
//   s_tready is high only while the sequencer is idle. A finished result waits
//   in the output register; while the receiver stalls with a result pending,
//   requests without a result keep flowing and the next result holds in the
//   done state until the register frees.
// ----------------------------------------------------------------------------
module weighted_histogram_range_sum #(
  parameter int unsigned NUM_BINS = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // configuration: sample weight
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [15:0] sample_value, [26:16] range_low,
                                 // [37:27] range_high, [39:38] zero
  input  logic [1:0]  s_tuser,   // [1:0] command
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // [31:0] range_total, [63:32] largest_total
  output logic [0:0]  m_tuser    // [0] status
);

  localparam int unsigned IDX_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned RW = (CNT_W > whrs_pkg::RANGE_W) ? CNT_W : whrs_pkg::RANGE_W;
  localparam int unsigned SW = whrs_pkg::SAMPLE_W + 1;
  localparam logic [RW-1:0] NB_RW = RW'(NUM_BINS);
  localparam logic [SW-1:0] NB_SW = SW'(NUM_BINS);
  localparam logic [CNT_W-1:0] LAST_BIN = CNT_W'(NUM_BINS - 1);

  // sequencer state
  whrs_pkg::state_t state, state_next;

  // datapath registers
  logic [whrs_pkg::WEIGHT_W-1:0] sample_weight;
  logic [whrs_pkg::DATA_W-1:0]   running_largest;
  logic [CNT_W-1:0]              ptr;
  logic [CNT_W-1:0]              end_ptr;
  logic                          rd_pend;
  logic [whrs_pkg::DATA_W-1:0]   acc;
  logic [IDX_W-1:0]              add_addr;
  logic                          res_status;
  logic [whrs_pkg::DATA_W-1:0]   res_total;

  // RAM port
  logic                        ram_we;
  logic [IDX_W-1:0]            ram_waddr;
  logic [whrs_pkg::DATA_W-1:0] ram_wdata;
  logic [IDX_W-1:0]            ram_raddr;
  logic [whrs_pkg::DATA_W-1:0] ram_rdata;

  // unpacked request fields
  whrs_pkg::cmd_t                in_cmd;
  logic [whrs_pkg::SAMPLE_W-1:0] in_val;
  logic [whrs_pkg::RANGE_W-1:0]  in_lo;
  logic [whrs_pkg::RANGE_W-1:0]  in_hi;

  logic                        accept;
  logic                        val_zero;
  logic                        val_fits;
  logic [RW-1:0]               hi_ext;
  logic [RW-1:0]               lo_ext;
  logic [RW-1:0]               hi_clamp;
  logic [RW-1:0]               lo_clamp;
  logic                        issue;
  logic                        walk_done;
  logic                        clear_last;
  logic                        out_free;
  logic [whrs_pkg::DATA_W-1:0] floored;
  logic [whrs_pkg::DATA_W-1:0] acc_sum;
  logic [whrs_pkg::DATA_W-1:0] bin_sum;

  assign in_cmd = whrs_pkg::cmd_t'(s_tuser);
  assign in_val = s_tdata[15:0];
  assign in_lo  = s_tdata[26:16];
  assign in_hi  = s_tdata[37:27];

  assign accept   = s_tvalid && s_tready;
  assign val_zero = (in_val == '0);
  assign val_fits = ({1'b0, in_val} < NB_SW);

  // clamp high to the store size, then low to high
  assign hi_ext   = RW'(in_hi);
  assign lo_ext   = RW'(in_lo);
  assign hi_clamp = (hi_ext > NB_RW) ? NB_RW : hi_ext;
  assign lo_clamp = (lo_ext > hi_clamp) ? hi_clamp : lo_ext;

  // bin walk: issue one read a cycle, fold it in the cycle after
  assign issue      = (state == whrs_pkg::ST_RANGE) && (ptr != end_ptr);
  assign walk_done  = (ptr == end_ptr) && !rd_pend;
  assign clear_last = (ptr == LAST_BIN);
  assign out_free   = !m_tvalid || m_tready;
  assign floored    = (running_largest == '0) ? whrs_pkg::DATA_W'(1) : running_largest;

  // the one shared saturating adder: bin update or range accumulate
  assign acc_sum = whrs_pkg::sat_add32((state == whrs_pkg::ST_ADD) ? ram_rdata : acc,
                                       (state == whrs_pkg::ST_ADD) ?
                                       whrs_pkg::DATA_W'(sample_weight) : ram_rdata);
  assign bin_sum = acc_sum;

  whrs_ram #(
    .WIDTH(whrs_pkg::DATA_W),
    .DEPTH(NUM_BINS)
  ) u_bins (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      whrs_pkg::ST_CLEAR: begin
        if (clear_last) state_next = whrs_pkg::ST_IDLE;
      end
      whrs_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_cmd)
            whrs_pkg::CMD_CLEAR_ALL: state_next = whrs_pkg::ST_CLEAR;
            whrs_pkg::CMD_ADD: begin
              if (val_zero)      state_next = whrs_pkg::ST_IDLE;
              else if (val_fits) state_next = whrs_pkg::ST_ADD;
              else               state_next = whrs_pkg::ST_DONE;
            end
            whrs_pkg::CMD_RANGE:     state_next = whrs_pkg::ST_RANGE;
            whrs_pkg::CMD_CLEAR_MAX: state_next = whrs_pkg::ST_IDLE;
            default:                 state_next = whrs_pkg::ST_IDLE;
          endcase
        end
      end
      whrs_pkg::ST_ADD:   state_next = whrs_pkg::ST_IDLE;
      whrs_pkg::ST_RANGE: begin
        if (walk_done) state_next = whrs_pkg::ST_DONE;
      end
      whrs_pkg::ST_DONE: begin
        if (out_free) state_next = whrs_pkg::ST_IDLE;
      end
      default: state_next = whrs_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and RAM port
  always_comb begin
    s_tready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = ptr[IDX_W-1:0];
    ram_wdata = '0;
    ram_raddr = ptr[IDX_W-1:0];
    case (state)
      whrs_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
      end
      whrs_pkg::ST_IDLE: begin
        s_tready  = 1'b1;
        // start the bin read for an add right away
        ram_raddr = in_val[IDX_W-1:0];
      end
      whrs_pkg::ST_ADD: begin
        ram_we    = 1'b1;
        ram_waddr = add_addr;
        ram_wdata = bin_sum;
      end
      whrs_pkg::ST_RANGE: begin
        ram_raddr = ptr[IDX_W-1:0];
      end
      whrs_pkg::ST_DONE: begin
        s_tready = 1'b0;
      end
      default: begin
        s_tready = 1'b0;
      end
    endcase
  end

  // state and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= whrs_pkg::ST_CLEAR;
      ptr             <= '0;
      rd_pend         <= 1'b0;
      running_largest <= '0;
      sample_weight   <= whrs_pkg::WEIGHT_W'(1);
    end else begin
      state <= state_next;

      if (cfg_wr_en) begin
        sample_weight <= cfg_wr_data;
      end

      case (state)
        whrs_pkg::ST_CLEAR: begin
          ptr <= ptr + CNT_W'(1);
        end
        whrs_pkg::ST_IDLE: begin
          if (accept) begin
            case (in_cmd)
              whrs_pkg::CMD_CLEAR_ALL: begin
                ptr             <= '0;
                running_largest <= '0;
              end
              whrs_pkg::CMD_ADD: begin
                add_addr   <= in_val[IDX_W-1:0];
                res_status <= 1'b1;
                res_total  <= '0;
              end
              whrs_pkg::CMD_RANGE: begin
                ptr     <= lo_clamp[CNT_W-1:0];
                end_ptr <= hi_clamp[CNT_W-1:0];
                acc     <= '0;
                rd_pend <= 1'b0;
              end
              whrs_pkg::CMD_CLEAR_MAX: begin
                running_largest <= '0;
              end
              default: begin
                running_largest <= running_largest;
              end
            endcase
          end
        end
        whrs_pkg::ST_RANGE: begin
          if (issue) ptr <= ptr + CNT_W'(1);
          rd_pend <= issue;
          if (rd_pend) acc <= acc_sum;
          if (walk_done) begin
            res_status <= 1'b0;
            res_total  <= acc;
            if (acc > running_largest) running_largest <= acc;
          end
        end
        default: begin
          rd_pend <= 1'b0;
        end
      endcase
    end
  end

  // output register: load from the done state, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == whrs_pkg::ST_DONE && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == whrs_pkg::ST_DONE && out_free) begin
      m_tuser <= res_status;
      m_tdata <= {floored, res_total};
    end
  end

  // checks
  a_walk_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == whrs_pkg::ST_RANGE) |-> (ptr <= end_ptr))
    else $error("range walk pointer ran past the end bin");

  a_clear_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && in_cmd == whrs_pkg::CMD_CLEAR_ALL) |=>
    (state == whrs_pkg::ST_CLEAR && ptr == '0 && running_largest == '0))
    else $error("clear-all request did not restart the clearing pass");

  a_max_covers_total: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tuser[0]) |-> (m_tdata[63:32] >= m_tdata[31:0]))
    else $error("running maximum below the reported range total");

  a_pend_in_walk: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> (state == whrs_pkg::ST_RANGE))
    else $error("pending bin read outside the range walk");

endmodule
